// ===== rtl/ktb_pkg.sv =====
// Shared types and constants of the keyed token bucket limiter.
package ktb_pkg;

  localparam int BUCKETS = 256;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;
  localparam int PER_W = 46;
  localparam int REM_W = 62;
  localparam int QUO_W = 16;

  localparam logic [PER_W-1:0] NS_PER_SEC_Q16 = 46'd65536000000000;
  localparam logic [REM_W-1:0] EARN_LIMIT = 62'd4294967296000000000;
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [31:0] EARN_RECIP = 32'd2305843009;
  localparam logic [19:0] NS_PER_MS = 20'd1000000;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_SWEEP = 1'b1;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_RATE = 2'd1;
  localparam logic [1:0] REG_TTL = 2'd2;

  typedef struct packed {
    logic             sweep;
    logic [IDX_W-1:0] idx;
    logic [63:0]      now;
  } ktb_item_t;

  typedef struct packed {
    logic [15:0] capacity;
    logic [31:0] rate;
    logic [31:0] ttl_ms;
  } ktb_cfg_t;

  typedef struct packed {
    logic             allowed;
    logic [15:0]      remaining;
    logic [63:0]      reset_time_ns;
    logic [63:0]      retry_after_ns;
    logic [CNT_W-1:0] evicted;
    logic [CNT_W-1:0] live_buckets;
  } ktb_result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SAT,
    ST_DIV,
    ST_UPDATE,
    ST_SW_TTL,
    ST_SWEEP,
    ST_OUT
  } ktb_state_t;

endpackage

// ===== rtl/ktb_front.sv =====
// Input queue that accepts items and classifies them as checks or sweeps.
module ktb_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    opcode,
  input  logic [ktb_pkg::IDX_W-1:0] bucket_index,
  input  logic [63:0]             now_ns,
  output logic                    item_valid,
  output ktb_pkg::ktb_item_t      item,
  input  logic                    item_take
);
  import ktb_pkg::*;

  ktb_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop = item_take && item_valid;
  assign item_valid = (count != 2'd0);
  assign item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (!do_push && do_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr].sweep <= (opcode == OP_SWEEP);
      slots[wr_ptr].idx <= bucket_index;
      slots[wr_ptr].now <= now_ns;
    end
  end

endmodule

// ===== rtl/ktb_period.sv =====
// Bit-serial divider that derives the token period from the refill rate.
module ktb_period (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [31:0]             rate,
  output logic [ktb_pkg::PER_W-1:0] period,
  output logic                    ready
);
  import ktb_pkg::*;

  logic             busy;
  logic [5:0]       bit_sel;
  logic [31:0]      rem;
  logic [PER_W-1:0] quo;
  logic [32:0]      trial;
  logic             ge;

  assign trial = {rem, NS_PER_SEC_Q16[bit_sel]};
  assign ge = (trial >= {1'b0, rate});
  assign ready = !busy;
  assign period = (rate == 32'd0) ? '0 : quo;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      bit_sel <= 6'(PER_W - 1);
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? 32'(trial - {1'b0, rate}) : trial[31:0];
      quo <= {quo[PER_W-2:0], ge};
      if (bit_sel == 6'd0) begin
        busy <= 1'b0;
      end else begin
        bit_sel <= bit_sel - 6'd1;
      end
    end
  end

endmodule

// ===== rtl/ktb_back.sv =====
// Bucket table and sequencer that carries out checks and sweeps.
module ktb_back (
  input  logic                    clk,
  input  logic                    rst,
  input  ktb_pkg::ktb_cfg_t       cfg,
  input  logic [ktb_pkg::PER_W-1:0] period,
  input  logic                    period_ready,
  input  logic                    item_valid,
  input  ktb_pkg::ktb_item_t      item,
  output logic                    item_take,
  output logic                    res_valid,
  output ktb_pkg::ktb_result_t    res,
  input  logic                    res_take
);
  import ktb_pkg::*;

  ktb_state_t state;
  ktb_state_t state_next;

  logic [15:0] tok_mem [BUCKETS];
  logic [63:0] last_mem [BUCKETS];
  logic [63:0] created_mem [BUCKETS];
  logic [15:0] tok_q;
  logic [63:0] last_q;
  logic [63:0] created_q;

  logic [BUCKETS-1:0] valid;
  logic [CNT_W-1:0]   live_count;
  ktb_item_t          cur;
  logic               is_new;
  logic [15:0]        tok_base;
  logic [63:0]        elapsed;
  logic [95:0]        prod;
  logic [QUO_W-1:0]   quo;
  logic [16:0]        earned;
  logic [CNT_W-1:0]   cnt;
  logic               p_vld;
  logic [IDX_W-1:0]   p_idx;
  logic [CNT_W-1:0]   evict_cnt;
  logic [63:0]        ttl_ns;

  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [31:0]      mul_a;
  logic [63:0]      mul_p;
  logic [51:0]      ttl_p;
  logic             sat;
  logic [63:0]      est_p;
  logic [45:0]      quo_ns;
  logic             ge;
  logic [17:0]      total;
  logic [15:0]      clamped;
  logic [15:0]      after;
  logic [15:0]      tok_wr;
  logic [64:0]      sum;
  logic             need_reset;
  logic [63:0]      age;
  logic             drop;

  assign mul_a = (state == ST_MUL_HI) ? elapsed[63:32] : elapsed[31:0];
  assign mul_p = mul_a * cfg.rate;
  assign ttl_p = cfg.ttl_ms * NS_PER_MS;
  assign sat = (prod[95:REM_W] != '0) || (prod[REM_W-1:0] >= EARN_LIMIT);
  assign est_p = prod[REM_W-1:30] * EARN_RECIP;
  assign quo_ns = {30'd0, quo} * {16'd0, NS_PER_SEC};
  assign ge = (prod[REM_W-1:16] >= (quo_ns + {16'd0, NS_PER_SEC}));
  assign total = {2'd0, tok_base} + {1'b0, earned};
  assign clamped = (total > {2'd0, cfg.capacity}) ? cfg.capacity : total[15:0];
  assign after = clamped - 16'd1;
  assign tok_wr = (clamped == 16'd0) ? 16'd0 : after;
  assign need_reset = (clamped == 16'd0) || (after == 16'd0);
  assign sum = {1'b0, cur.now} + {{(65-PER_W){1'b0}}, period};
  assign age = cur.now - created_q;
  assign drop = p_vld && valid[p_idx] && (age > ttl_ns);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid && period_ready) begin
          state_next = item.sweep ? ST_SW_TTL : ST_READ;
        end
      end
      ST_READ: state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_SAT;
      ST_SAT: state_next = sat ? ST_UPDATE : ST_DIV;
      ST_DIV: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_OUT;
      ST_SW_TTL: state_next = ST_SWEEP;
      ST_SWEEP: begin
        if (cnt[CNT_W-1] && !p_vld) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_take = 1'b0;
    res_valid = 1'b0;
    wr_en = 1'b0;
    rd_addr = cur.idx;
    case (state)
      ST_IDLE: begin
        item_take = item_valid && period_ready;
        rd_addr = item.idx;
      end
      ST_SWEEP: rd_addr = cnt[IDX_W-1:0];
      ST_UPDATE: wr_en = 1'b1;
      ST_OUT: res_valid = 1'b1;
      default: rd_addr = cur.idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tok_mem[cur.idx] <= tok_wr;
      last_mem[cur.idx] <= cur.now;
      if (is_new) begin
        created_mem[cur.idx] <= cur.now;
      end
    end
    tok_q <= tok_mem[rd_addr];
    last_q <= last_mem[rd_addr];
    created_q <= created_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      live_count <= '0;
    end else if (state == ST_UPDATE && is_new) begin
      valid[cur.idx] <= 1'b1;
      live_count <= live_count + CNT_W'(1);
    end else if (state == ST_SWEEP) begin
      if (drop) begin
        valid[p_idx] <= 1'b0;
      end
      if (cnt[CNT_W-1] && !p_vld) begin
        live_count <= live_count - evict_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: cur <= item;
      ST_READ: begin
        is_new <= !valid[cur.idx];
        tok_base <= valid[cur.idx] ? tok_q : cfg.capacity;
        elapsed <= valid[cur.idx] ? (cur.now - last_q) : 64'd0;
      end
      ST_MUL_LO: prod <= {32'd0, mul_p};
      ST_MUL_HI: prod <= prod + {mul_p, 32'd0};
      ST_SAT: begin
        earned <= 17'h10000;
        quo <= est_p[62:47];
      end
      ST_DIV: begin
        earned <= {1'b0, quo + {{(QUO_W-1){1'b0}}, ge}};
      end
      ST_UPDATE: begin
        res.allowed <= (clamped != 16'd0);
        res.remaining <= tok_wr;
        res.reset_time_ns <= need_reset ? sum[63:0] : cur.now;
        res.retry_after_ns <= (need_reset && !sum[64]) ? {{(64-PER_W){1'b0}}, period} : 64'd0;
        res.evicted <= '0;
        res.live_buckets <= live_count + {{(CNT_W-1){1'b0}}, is_new};
      end
      ST_SW_TTL: begin
        ttl_ns <= {12'd0, ttl_p};
        cnt <= '0;
        p_vld <= 1'b0;
        evict_cnt <= '0;
      end
      ST_SWEEP: begin
        p_vld <= !cnt[CNT_W-1];
        p_idx <= cnt[IDX_W-1:0];
        if (!cnt[CNT_W-1]) begin
          cnt <= cnt + CNT_W'(1);
        end
        if (drop) begin
          evict_cnt <= evict_cnt + CNT_W'(1);
        end
        res.allowed <= 1'b0;
        res.remaining <= '0;
        res.reset_time_ns <= '0;
        res.retry_after_ns <= '0;
        res.evicted <= evict_cnt;
        res.live_buckets <= live_count - evict_cnt;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/keyed_token_bucket_limiter.sv =====
// Top level of the keyed token bucket limiter with configuration and result slot.
//
// A check passes from acceptance through the input queue, a table read, the two
// halves of the elapsed time times rate product on the shared 32 by 32
// multiplier, a saturation test that also estimates the earned tokens by a
// reciprocal multiply, a one-step correction of that estimate, the table update,
// and the move into the output slot; a saturated refill skips the correction.
// The sequencer handles one item at a time, so it takes a new item only after
// the previous result has moved into the output slot. A sweep walks all 256
// buckets one per cycle. A write to the refill rate starts a bit-serial
// division for the token period, and items wait for it to finish. Two items
// can queue at the input and one finished result waits at the output.
module keyed_token_bucket_limiter (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    opcode,
  input  logic [ktb_pkg::IDX_W-1:0] bucket_index,
  input  logic [63:0]             now_ns,
  output logic                    empty,
  input  logic                    pop,
  output logic                    allowed,
  output logic [15:0]             remaining,
  output logic [63:0]             reset_time_ns,
  output logic [63:0]             retry_after_ns,
  output logic [ktb_pkg::CNT_W-1:0] evicted,
  output logic [ktb_pkg::CNT_W-1:0] live_buckets,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data
);
  import ktb_pkg::*;

  ktb_cfg_t         cfg;
  ktb_item_t        item;
  ktb_result_t      res;
  ktb_result_t      slot;
  logic             item_valid;
  logic             item_take;
  logic             res_valid;
  logic             res_take;
  logic             rate_wr;
  logic [PER_W-1:0] period;
  logic             period_ready;

  assign cfg_ready = 1'b1;
  assign rate_wr = cfg_valid && (cfg_index == REG_RATE);
  assign res_take = res_valid && (empty || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity <= 16'd100;
      cfg.rate <= 32'd655360;
      cfg.ttl_ms <= 32'd60000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAPACITY: cfg.capacity <= cfg_data[15:0];
        REG_RATE: cfg.rate <= cfg_data;
        REG_TTL: cfg.ttl_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty <= 1'b1;
    end else if (res_take) begin
      empty <= 1'b0;
    end else if (pop) begin
      empty <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      slot <= res;
    end
  end

  assign allowed = slot.allowed;
  assign remaining = slot.remaining;
  assign reset_time_ns = slot.reset_time_ns;
  assign retry_after_ns = slot.retry_after_ns;
  assign evicted = slot.evicted;
  assign live_buckets = slot.live_buckets;

  ktb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .bucket_index (bucket_index),
    .now_ns       (now_ns),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  ktb_period u_period (
    .clk    (clk),
    .rst    (rst),
    .start  (rate_wr),
    .rate   (cfg.rate),
    .period (period),
    .ready  (period_ready)
  );

  ktb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .period       (period),
    .period_ready (period_ready),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

endmodule
